[rtl/infix_calculator_stream_assert.svh]
// assertion macros for the infix calculator stream block
`ifndef INFIX_CALCULATOR_STREAM_ASSERT_SVH
`define INFIX_CALCULATOR_STREAM_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ICALC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icalc same-cycle check failed");

// next-cycle implication, checked out of reset
`define ICALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icalc next-cycle check failed");

`endif

[rtl/icalc_pkg.sv]
// shared types and constants of the infix calculator stream block
package icalc_pkg;

  // default term width and width of the running sum
  localparam int unsigned ICALC_WIDTH = 32;
  localparam int unsigned SUM_W       = 64;

  // ascii codes of the recognised characters
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // radix for digit accumulation
  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  // pending operator codes
  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_e;

  // operations of the shared shift/add unit
  typedef enum logic {
    UNIT_MUL = 1'b0,
    UNIT_DIV = 1'b1
  } unit_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_EMIT = 2'd2
  } seq_state_e;

  // sequencer to unit control
  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctl_t;

  // unit to sequencer status
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[rtl/icalc_shift_unit.sv]
// shared iterative shift/add unit: modular multiply and unsigned restoring divide
module icalc_shift_unit import icalc_pkg::*; #(
  parameter int unsigned WIDTH = ICALC_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_ctl_t        ctl_i,
  input  logic [WIDTH-1:0] opa_i,     // multiplicand or dividend
  input  logic [WIDTH-1:0] opb_i,     // multiplier or divisor
  output unit_sts_t        sts_o,
  output logic [WIDTH-1:0] result_o   // product mod 2^WIDTH or quotient
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  unit_op_e         op_q;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] acc_q, acc_d;

  logic [WIDTH:0]   add_a, add_b;
  logic             add_cin;
  logic [WIDTH+1:0] add_sum;
  logic             last_step;

  assign last_step = busy_q && (cnt_q == CntW'(1));

  // single shared adder, operands chosen by operation
  always_comb begin
    if (op_q == UNIT_DIV) begin
      add_a   = {acc_q, x_q[WIDTH-1]};
      add_b   = ~{1'b0, y_q};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, acc_q};
      add_b   = {1'b0, (y_q[0] ? x_q : '0)};
      add_cin = 1'b0;
    end
    add_sum = (WIDTH+2)'(add_a) + (WIDTH+2)'(add_b) + (WIDTH+2)'(add_cin);
  end

  // one iteration of multiply or divide
  always_comb begin
    if (op_q == UNIT_DIV) begin
      y_d = y_q;
      // carry out set means partial remainder not below divisor
      if (add_sum[WIDTH+1]) begin
        acc_d = add_sum[WIDTH-1:0];
        x_d   = {x_q[WIDTH-2:0], 1'b1};
      end else begin
        acc_d = add_a[WIDTH-1:0];
        x_d   = {x_q[WIDTH-2:0], 1'b0};
      end
    end else begin
      acc_d = add_sum[WIDTH-1:0];
      x_d   = {x_q[WIDTH-2:0], 1'b0};
      y_d   = {1'b0, y_q[WIDTH-1:1]};
    end
  end

  // iteration counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q  <= ctl_i.op;
      x_q   <= opa_i;
      y_q   <= opb_i;
      acc_q <= '0;
    end else if (busy_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = (op_q == UNIT_DIV) ? x_q : acc_q;

endmodule

[rtl/icalc_seq.sv]
// character decoder, expression state and sequencer of the calculator
module icalc_seq import icalc_pkg::*; #(
  parameter int unsigned WIDTH = ICALC_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // incoming character word
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  input  logic             in_last_i,
  // shared unit
  output unit_ctl_t        unit_ctl_o,
  output logic [WIDTH-1:0] unit_opa_o,
  output logic [WIDTH-1:0] unit_opb_o,
  input  unit_sts_t        unit_sts_i,
  input  logic [WIDTH-1:0] unit_res_i,
  // result towards the output register
  input  logic             out_free_i,
  output logic             emit_o,
  output logic [SUM_W-1:0] emit_value_o,
  output logic             emit_err_o
);

  seq_state_e       state_q, state_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [WIDTH-1:0] term_q, term_d;
  logic [WIDTH-1:0] num_q, num_d;
  op_e              pend_q, pend_d;
  logic             err_q, err_d;
  logic             last_q, last_d;
  logic             neg_q, neg_d;

  logic             accept;
  logic             is_digit;
  logic             is_op;
  op_e              new_op;
  logic [WIDTH-1:0] num_next;
  logic [SUM_W-1:0] term_ext;
  logic [WIDTH-1:0] term_mag, num_mag;

  assign accept   = in_valid_i && in_ready_o;
  assign is_digit = in_char_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign term_ext = SUM_W'($signed(term_q));
  assign num_next = is_digit ? WIDTH'(num_q * DECIMAL_BASE) + WIDTH'(in_char_i[3:0]) : num_q;
  assign term_mag = term_q[WIDTH-1] ? -term_q : term_q;
  assign num_mag  = num_next[WIDTH-1] ? -num_next : num_next;

  // operator decode
  always_comb begin
    is_op  = 1'b1;
    new_op = OP_PLUS;
    case (in_char_i)
      CHAR_PLUS:   new_op = OP_PLUS;
      CHAR_MINUS:  new_op = OP_MINUS;
      CHAR_TIMES:  new_op = OP_TIMES;
      CHAR_DIVIDE: new_op = OP_DIVIDE;
      default:     is_op  = 1'b0;
    endcase
  end

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    term_d       = term_q;
    num_d        = num_q;
    pend_d       = pend_q;
    err_d        = err_q;
    last_d       = last_q;
    neg_d        = neg_q;
    in_ready_o   = 1'b0;
    unit_ctl_o   = '{start: 1'b0, op: UNIT_MUL};
    unit_opa_o   = term_q;
    unit_opb_o   = num_next;
    emit_o       = 1'b0;
    emit_value_o = err_q ? '0 : sum_q + term_ext;
    emit_err_o   = err_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          last_d = in_last_i;
          if (is_op) begin
            pend_d = new_op;
          end
          if (is_op || in_last_i) begin
            num_d = '0;
            if (in_last_i) begin
              state_d = ST_EMIT;
            end
            case (pend_q)
              OP_PLUS: begin
                sum_d  = sum_q + term_ext;
                term_d = num_next;
              end
              OP_MINUS: begin
                sum_d  = sum_q + term_ext;
                term_d = -num_next;
              end
              OP_TIMES: begin
                unit_ctl_o = '{start: 1'b1, op: UNIT_MUL};
                neg_d      = 1'b0;
                state_d    = ST_BUSY;
              end
              default: begin
                // divide: zero divisor clears the term and flags the error
                if (num_next == '0) begin
                  err_d  = 1'b1;
                  term_d = '0;
                end else begin
                  unit_ctl_o = '{start: 1'b1, op: UNIT_DIV};
                  unit_opa_o = term_mag;
                  unit_opb_o = num_mag;
                  neg_d      = term_q[WIDTH-1] ^ num_next[WIDTH-1];
                  state_d    = ST_BUSY;
                end
              end
            endcase
          end else begin
            num_d = num_next;
          end
        end
      end

      ST_BUSY: begin
        // write back product or signed quotient
        if (unit_sts_i.done) begin
          term_d  = neg_q ? -unit_res_i : unit_res_i;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        // hand the total over and return to the reset state
        if (out_free_i) begin
          emit_o  = 1'b1;
          sum_d   = '0;
          term_d  = '0;
          num_d   = '0;
          pend_d  = OP_PLUS;
          err_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      term_q  <= '0;
      num_q   <= '0;
      pend_q  <= OP_PLUS;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      term_q  <= term_d;
      num_q   <= num_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      last_q  <= last_d;
      neg_q   <= neg_d;
    end
  end

endmodule

[rtl/infix_calculator_stream.sv]
// digits, spaces, + and - are taken one word per cycle while the sequencer is idle;
// * and / run WIDTH iterations of the shared shift/add unit and hold the input off
// until it is done; / by zero does not start the unit; a word with tlast passes the
// emit state before the total enters the output register, later while that is full;
// reset clears the sequencer state, the unit handshake and the output valid
// top level: stream ports, output register, sequencer and shared unit
module infix_calculator_stream import icalc_pkg::*; #(
  parameter int unsigned WIDTH = ICALC_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] character
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [SUM_W-1:0] m_axis_tdata_o,   // [63:0] value
  output logic             m_axis_tuser_o    // [0] divide_by_zero
);

  `include "infix_calculator_stream_assert.svh"

  unit_ctl_t        unit_ctl;
  unit_sts_t        unit_sts;
  logic [WIDTH-1:0] unit_opa, unit_opb, unit_res;
  logic             out_free;
  logic             emit;
  logic [SUM_W-1:0] emit_value;
  logic             emit_err;
  logic             m_valid_q;
  logic [SUM_W-1:0] m_data_q;
  logic             m_user_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  icalc_seq #(
    .WIDTH (WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_char_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .unit_ctl_o   (unit_ctl),
    .unit_opa_o   (unit_opa),
    .unit_opb_o   (unit_opb),
    .unit_sts_i   (unit_sts),
    .unit_res_i   (unit_res),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .emit_value_o (emit_value),
    .emit_err_o   (emit_err)
  );

  icalc_shift_unit #(
    .WIDTH (WIDTH)
  ) u_shift_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (unit_ctl),
    .opa_i    (unit_opa),
    .opb_i    (unit_opb),
    .sts_o    (unit_sts),
    .result_o (unit_res)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= emit_value;
      m_user_q <= emit_err;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // checks
  `ICALC_ASSERT_IMPL(a_emit_needs_room, emit, out_free)
  `ICALC_ASSERT_IMPL(a_err_value_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)
  `ICALC_ASSERT_IMPL(a_no_accept_while_busy, unit_sts.busy, !s_axis_tready_o)
  `ICALC_ASSERT_NEXT(a_start_runs_unit, unit_ctl.start, unit_sts.busy)

endmodule

[test/tb.sv]
// self-checking testbench for the streaming infix calculator, directed and random expressions
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icalc_pkg::*;

  localparam int unsigned W          = ICALC_WIDTH;
  localparam int unsigned STALL_MAX  = 3000;
  localparam int unsigned PHASE_OPS  = 375;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  OP_CHARS [4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIVIDE};

  // sender idle and receiver stall percentages per phase
  localparam int unsigned IDLE_TAB  [4] = '{0, 88, 0, 30};
  localparam int unsigned STALL_TAB [4] = '{0, 0, 88, 30};

  // one input word and one output total
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct {
    logic [63:0] value;
    logic        dbz;
  } total_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i  = 8'h00;   // [7:0] character
  logic             s_axis_tlast_i  = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [SUM_W-1:0] m_axis_tdata_o;            // [63:0] value
  logic             m_axis_tuser_o;            // [0] divide_by_zero

  // stimulus and expectation stores
  char_word_t char_q[$];
  logic [7:0] expr_buf[$];
  total_t     total_q[$];

  // evaluator state
  logic [63:0]  sum_reg    = '0;
  logic [W-1:0] term_reg   = '0;
  logic [W-1:0] number_reg = '0;
  op_e          pend_op    = OP_PLUS;
  logic         dbz_seen   = 1'b0;

  // run control and statistics
  int unsigned send_idle    = 0;
  int unsigned recv_stall   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned total_cnt    = 0;
  int unsigned dbz_cnt      = 0;
  int unsigned expr_cnt     = 0;
  int unsigned item_cnt     = 0;
  int unsigned quiet_cnt    = 0;

  infix_calculator_stream #(
    .WIDTH (W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // evaluate one accepted character, queue a total on the final one
  task automatic eval_char(input logic [7:0] ch, input logic last);
    logic        is_op;
    op_e         new_op;
    logic [63:0] ext_a, ext_b, mag_a, mag_b, quo;
    total_t      res;
    is_op  = 1'b0;
    new_op = OP_PLUS;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      number_reg = W'(number_reg * DECIMAL_BASE + (ch - CHAR_ZERO));
    end else begin
      case (ch)
        CHAR_PLUS: begin
          is_op = 1'b1; new_op = OP_PLUS;
        end
        CHAR_MINUS: begin
          is_op = 1'b1; new_op = OP_MINUS;
        end
        CHAR_TIMES: begin
          is_op = 1'b1; new_op = OP_TIMES;
        end
        CHAR_DIVIDE: begin
          is_op = 1'b1; new_op = OP_DIVIDE;
        end
        default: ;
      endcase
    end
    // close the operand under the pending operator
    if (is_op || last) begin
      case (pend_op)
        OP_PLUS, OP_MINUS: begin
          sum_reg  = sum_reg + 64'($signed(term_reg));
          term_reg = (pend_op == OP_PLUS) ? number_reg : W'(-number_reg);
        end
        OP_TIMES: begin
          term_reg = W'(term_reg * number_reg);
        end
        default: begin
          if (number_reg == '0) begin
            dbz_seen = 1'b1;
            term_reg = '0;
          end else begin
            // truncating division on magnitudes, so min / -1 wraps
            ext_a = 64'($signed(term_reg));
            ext_b = 64'($signed(number_reg));
            mag_a = ext_a[63] ? -ext_a : ext_a;
            mag_b = ext_b[63] ? -ext_b : ext_b;
            quo   = mag_a / mag_b;
            if (ext_a[63] != ext_b[63]) quo = -quo;
            term_reg = quo[W-1:0];
          end
        end
      endcase
      number_reg = '0;
      if (is_op) pend_op = new_op;
    end
    // final character: emit total and clear
    if (last) begin
      res.dbz   = dbz_seen;
      res.value = dbz_seen ? 64'd0 : sum_reg + 64'($signed(term_reg));
      total_q.push_back(res);
      sum_reg    = '0;
      term_reg   = '0;
      number_reg = '0;
      pend_op    = OP_PLUS;
      dbz_seen   = 1'b0;
    end
  endtask

  // sender: one word held until accepted, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
      s_axis_tlast_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) eval_char(s_axis_tdata_i, s_axis_tlast_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= char_q[0].ch;
          s_axis_tlast_i  <= char_q[0].last;
          void'(char_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    total_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      total_cnt++;
      if (m_axis_tuser_o) dbz_cnt++;
      if (total_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected total %0d dbz %0b", $signed(m_axis_tdata_o), m_axis_tuser_o);
      end else begin
        want = total_q.pop_front();
        if (m_axis_tdata_o !== want.value || m_axis_tuser_o !== want.dbz) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("total mismatch: expected %0d dbz %0b, got %0d dbz %0b",
                     $signed(want.value), want.dbz, $signed(m_axis_tdata_o), m_axis_tuser_o);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= STALL_MAX) begin
        $display("timeout after %0d quiet cycles", quiet_cnt);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // append a string to the expression being built
  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
  endtask

  // move the built expression to the send queue, tlast on its final word
  task automatic flush_expr();
    char_word_t w;
    foreach (expr_buf[i]) begin
      w.ch   = expr_buf[i];
      w.last = (i == expr_buf.size() - 1);
      char_q.push_back(w);
      if ((w.ch >= CHAR_ZERO && w.ch <= CHAR_NINE) || w.ch inside {OP_CHARS})
        item_cnt++;
    end
    expr_buf.delete();
    expr_cnt++;
  endtask

  // operand text, mostly short, sometimes wrapping or at a boundary
  function automatic string rand_number();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $sformatf("%0d", $urandom_range(0, 99));
      5, 6:          return $sformatf("%0d", $urandom_range(0, 99999));
      7:             return $sformatf("%0d", $urandom);
      8:             return $sformatf("%0d", {$urandom, $urandom});
      default: begin
        case ($urandom_range(0, 7))
          0: return "0";
          1: return "00";
          2: return "1";
          3: return "2147483647";
          4: return "2147483648";
          5: return "4294967295";
          6: return "4294967296";
          default: return "0009";
        endcase
      end
    endcase
  endfunction

  // random expression with spaces, noise bytes and the odd missing operand
  task automatic gen_expr();
    int n_terms;
    n_terms = $urandom_range(1, 6);
    for (int t = 0; t < n_terms; t++) begin
      if ($urandom_range(0, 19) == 0) expr_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) expr_buf.push_back(CHAR_SPACE);
      if ($urandom_range(0, 24) != 0) push_str(rand_number());
      if ($urandom_range(0, 3) == 0) expr_buf.push_back(CHAR_SPACE);
      if (t < n_terms - 1) expr_buf.push_back(OP_CHARS[$urandom_range(0, 3)]);
    end
    // ending: usually on a digit, sometimes a space, operator or stray byte
    case ($urandom_range(0, 9))
      0: expr_buf.push_back(CHAR_SPACE);
      1: expr_buf.push_back(OP_CHARS[$urandom_range(0, 3)]);
      2: expr_buf.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    if (expr_buf.size() == 0) expr_buf.push_back(8'($urandom_range(0, 255)));
    flush_expr();
  endtask

  // reset, directed expressions, then the random phases
  initial begin
    int unsigned goal;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // precedence across all four operators
    push_str("3+4*5-6/2");
    flush_expr();
    // zero divisor
    push_str("7/0");
    flush_expr();
    // stray byte as the whole expression
    expr_buf.push_back(8'hFF);
    flush_expr();
    // operator as final word
    push_str("8-");
    flush_expr();
    // most negative term divided by minus one
    push_str("2147483648/4294967295");
    flush_expr();

    for (int p = 0; p < 4; p++) begin
      send_idle  = IDLE_TAB[p];
      recv_stall = STALL_TAB[p];
      goal = item_cnt + PHASE_OPS;
      while (item_cnt < goal) gen_expr();
      wait (char_q.size() == 0 && !s_axis_tvalid_i && total_q.size() == 0);
      @(negedge clk_i);
    end

    repeat (2 * W + 10) @(posedge clk_i);
    $display("ran %0d expressions with %0d digit and operator words over four idle/stall mixes",
             expr_cnt, item_cnt);
    $display("checked %0d totals, %0d with divide by zero; %0d mismatches, %0d still expected",
             total_cnt, dbz_cnt, mismatch_cnt, total_q.size());
    if (mismatch_cnt == 0 && total_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
